// ===== rtl/cds_pkg.sv =====
// Shared types, codes and constants for the critically damped smoother.
package cds_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SER_W = 64;

    // register indexes
    localparam logic [1:0] CFG_SMOOTH_TIME = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED   = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP   = 2'd2;

    localparam logic [31:0] SMOOTH_TIME_RST = 32'd65536;
    localparam logic [30:0] MAX_SPEED_RST   = 31'h7FFF_FFFF;
    localparam logic [16:0] TIME_STEP_RST   = 17'd1092;

    // decay polynomial coefficients: 0.48 = 48/100, 0.235 = 235/1000
    localparam logic [63:0] C2_NUM = 64'd48;
    localparam logic [63:0] C3_NUM = 64'd235;

    // exact floor division by 100 and 1000 as multiply by a rounded-up
    // reciprocal and a right shift; exact for dividends below 2^62
    localparam int          C2_SHIFT = 70;
    localparam logic [63:0] C2_RCP   = 64'((128'd1 << C2_SHIFT) / 128'd100 + 128'd1);
    localparam int          C3_SHIFT = 73;
    localparam logic [63:0] C3_RCP   = 64'((128'd1 << C3_SHIFT) / 128'd1000 + 128'd1);

    // per-item micro-steps (one per cycle)
    localparam logic [3:0] ST_CLAMP = 4'd0;
    localparam logic [3:0] ST_M1    = 4'd1;
    localparam logic [3:0] ST_A1    = 4'd2;
    localparam logic [3:0] ST_M2    = 4'd3;
    localparam logic [3:0] ST_A2    = 4'd4;
    localparam logic [3:0] ST_M3    = 4'd5;
    localparam logic [3:0] ST_A3    = 4'd6;
    localparam logic [3:0] ST_M4    = 4'd7;
    localparam logic [3:0] ST_A4    = 4'd8;
    localparam logic [3:0] ST_M5    = 4'd9;
    localparam logic [3:0] ST_A5    = 4'd10;

    // coefficient derivation operations (each on the serial unit)
    localparam logic [2:0] D_OMEGA = 3'd0;
    localparam logic [2:0] D_X     = 3'd1;
    localparam logic [2:0] D_X2    = 3'd2;
    localparam logic [2:0] D_X3    = 3'd3;
    localparam logic [2:0] D_T1    = 3'd4;
    localparam logic [2:0] D_T2    = 3'd5;
    localparam logic [2:0] D_DEC   = 3'd6;
    localparam logic [2:0] D_LIM   = 3'd7;

    typedef struct packed {
        logic       load;
        logic       step_en;
        logic [3:0] step_op;
        logic       d_issue;
        logic       d_wb;
        logic [2:0] d_op;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic ser_done;
        logic x_big;
    } stat_t;

endpackage

// ===== rtl/cds_serial.sv =====
// Bit-serial unit: shift-add multiply or restoring divide, one bit per cycle.
module cds_serial (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        is_div,
    input  logic [cds_pkg::SER_W-1:0]   opa,
    input  logic [cds_pkg::SER_W-1:0]   opb,
    output logic [2*cds_pkg::SER_W-1:0] prod,
    output logic [cds_pkg::SER_W-1:0]   quo,
    output logic                        done
);
    import cds_pkg::*;

    localparam int CW = $clog2(SER_W);

    logic [SER_W-1:0] hi_reg, hi_next, lo_reg, lo_next, b_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, div_reg, done_reg;
    logic [SER_W:0]   msum, shifted;

    always_comb begin
        msum    = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b_reg} : '0);
        shifted = {hi_reg, lo_reg[SER_W-1]};
        if (div_reg) begin
            if (shifted >= {1'b0, b_reg}) begin
                hi_next = SER_W'(shifted - {1'b0, b_reg});
                lo_next = {lo_reg[SER_W-2:0], 1'b1};
            end else begin
                hi_next = shifted[SER_W-1:0];
                lo_next = {lo_reg[SER_W-2:0], 1'b0};
            end
        end else begin
            hi_next = msum[SER_W:1];
            lo_next = {msum[0], lo_reg[SER_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(SER_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= is_div;
            if (is_div) begin
                hi_reg <= '0;
                lo_reg <= opa;
                b_reg  <= opb;
            end else begin
                hi_reg <= '0;
                lo_reg <= opb;
                b_reg  <= opa;
            end
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign prod = {hi_reg, lo_reg};
    assign quo  = lo_reg;
    assign done = done_reg;

endmodule

// ===== rtl/cds_dp.sv =====
// Datapath: settings, derived coefficients, step arithmetic and result register.
module cds_dp #(
    parameter int FRAC_BITS = cds_pkg::FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cds_pkg::cmd_t cmd,
    output cds_pkg::stat_t stat,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,
    input  logic [63:0]   in_data,
    output logic [63:0]   out_data
);
    import cds_pkg::*;

    localparam logic [63:0] ONE_Q      = 64'd1 << FRAC_BITS;
    localparam logic [31:0] MIN_SMOOTH = 32'(((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000);
    localparam logic [63:0] OM_NUM     = 64'd1 << (2 * FRAC_BITS + 1);
    localparam logic [63:0] DEC_NUM    = 64'd1 << (2 * FRAC_BITS);
    localparam logic [63:0] X_MAX      = 64'd1 << (FRAC_BITS + 10);
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) return v[32] ? S_MIN : S_MAX;
        return v[31:0];
    endfunction

    // settings and coefficients
    logic [31:0] smooth_reg;
    logic [30:0] speed_reg;
    logic [16:0] step_reg;
    logic [31:0] omega_reg, decay_reg, limit_reg;
    logic [63:0] x_reg, x2_reg, x3_reg, den_reg;
    logic [31:0] st;

    // step registers
    logic signed [31:0] cur_reg, goal_reg, change_reg, tgt_reg, acc_reg, temp_reg;
    logic signed [31:0] nv_reg, res_reg, vel_reg, o_res_reg, o_nv_reg;
    logic [63:0] prod_reg;
    logic        neg_reg;

    // serial unit
    logic              ser_start, ser_div, ser_done;
    logic [63:0]       ser_a, ser_b, ser_quo, ser_hi;
    logic [127:0]      ser_prod;

    cds_serial u_ser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ser_start),
        .is_div  (ser_div),
        .opa     (ser_a),
        .opb     (ser_b),
        .prod    (ser_prod),
        .quo     (ser_quo),
        .done    (ser_done)
    );

    assign st     = (smooth_reg < MIN_SMOOTH) ? MIN_SMOOTH : smooth_reg;
    assign ser_hi = ser_prod[FRAC_BITS +: 64];

    always_comb begin
        ser_start = cmd.d_issue;
        ser_div   = 1'b0;
        ser_a     = '0;
        ser_b     = '0;
        case (cmd.d_op)
            D_OMEGA: begin ser_div = 1'b1; ser_a = OM_NUM; ser_b = {32'd0, st}; end
            D_X:     begin ser_a = {32'd0, omega_reg}; ser_b = {47'd0, step_reg}; end
            D_X2:    begin ser_a = x_reg; ser_b = x_reg; end
            D_X3:    begin ser_a = x2_reg; ser_b = x_reg; end
            D_T1:    begin ser_a = x2_reg * C2_NUM; ser_b = C2_RCP; end
            D_T2:    begin ser_a = x3_reg * C3_NUM; ser_b = C3_RCP; end
            D_DEC:   begin ser_div = 1'b1; ser_a = DEC_NUM; ser_b = den_reg; end
            D_LIM:   begin ser_a = {33'd0, speed_reg}; ser_b = {32'd0, st}; end
            default: begin ser_a = '0; ser_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= SMOOTH_TIME_RST;
            speed_reg  <= MAX_SPEED_RST;
            step_reg   <= TIME_STEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SMOOTH_TIME: smooth_reg <= cfg_wdata;
                CFG_MAX_SPEED:   speed_reg  <= cfg_wdata[30:0];
                CFG_TIME_STEP:   step_reg   <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.d_wb) begin
            case (cmd.d_op)
                D_OMEGA: omega_reg <= (|ser_quo[63:31]) ? 32'h7FFF_FFFF : ser_quo[31:0];
                D_X: begin
                    x_reg     <= ser_hi;
                    decay_reg <= '0;
                end
                D_X2:    x2_reg  <= ser_hi;
                D_X3:    x3_reg  <= ser_hi;
                D_T1:    den_reg <= ONE_Q + x_reg + 64'(ser_prod >> C2_SHIFT);
                D_T2:    den_reg <= den_reg + 64'(ser_prod >> C3_SHIFT);
                D_DEC:   decay_reg <= ser_quo[31:0];
                D_LIM:   limit_reg <= (|ser_hi[63:31]) ? 32'h7FFF_FFFF : ser_hi[31:0];
                default: ;
            endcase
        end
    end

    assign stat.ser_done = ser_done;
    assign stat.x_big    = (x_reg > X_MAX);

    // step arithmetic
    logic signed [31:0] mq, op_a, op_b, change_c;
    logic signed [32:0] diff, lim33;
    logic [63:0]        mag;
    logic [31:0]        abs_a, abs_b;

    always_comb begin
        mag = prod_reg >> FRAC_BITS;
        if (|mag[63:31]) mq = neg_reg ? S_MIN : S_MAX;
        else             mq = neg_reg ? -$signed(mag[31:0]) : $signed(mag[31:0]);

        diff  = {cur_reg[31], cur_reg} - {goal_reg[31], goal_reg};
        lim33 = {1'b0, limit_reg};
        if (diff > lim33)       change_c = limit_reg;
        else if (diff < -lim33) change_c = -$signed(limit_reg);
        else                    change_c = diff[31:0];

        op_a = acc_reg;
        op_b = $signed(decay_reg);
        case (cmd.step_op)
            ST_M1:   begin op_a = $signed(omega_reg); op_b = change_reg; end
            ST_M2:   begin op_a = acc_reg; op_b = $signed({15'd0, step_reg}); end
            ST_M3:   begin op_a = $signed(omega_reg); op_b = temp_reg; end
            default: begin op_a = acc_reg; op_b = $signed(decay_reg); end
        endcase
        abs_a = op_a[31] ? 32'(-op_a) : op_a;
        abs_b = op_b[31] ? 32'(-op_b) : op_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg <= '0;
        end else begin
            if (cmd.load) begin
                cur_reg  <= in_data[31:0];
                goal_reg <= in_data[63:32];
            end
            if (cmd.step_en) begin
                case (cmd.step_op)
                    ST_CLAMP: begin
                        change_reg <= change_c;
                        tgt_reg    <= 32'(cur_reg - change_c);
                    end
                    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5: begin
                        prod_reg <= abs_a * abs_b;
                        neg_reg  <= op_a[31] ^ op_b[31];
                    end
                    ST_A1: acc_reg  <= sat33(33'(vel_reg) + 33'(mq));
                    ST_A2: temp_reg <= mq;
                    ST_A3: acc_reg  <= sat33(33'(vel_reg) - 33'(mq));
                    ST_A4: begin
                        nv_reg  <= mq;
                        acc_reg <= sat33(33'(change_reg) + 33'(temp_reg));
                    end
                    ST_A5: res_reg <= sat33(33'(tgt_reg) + 33'(mq));
                    default: ;
                endcase
            end
            if (cmd.out_load) begin
                // overshoot past the goal: snap to goal, stop
                if ((goal_reg > cur_reg) == (res_reg > goal_reg)) begin
                    o_res_reg <= goal_reg;
                    o_nv_reg  <= '0;
                    vel_reg   <= '0;
                end else begin
                    o_res_reg <= res_reg;
                    o_nv_reg  <= nv_reg;
                    vel_reg   <= nv_reg;
                end
            end
        end
    end

    assign out_data = {o_nv_reg, o_res_reg};

endmodule

// ===== rtl/cds_ctrl.sv =====
// Controller: sequences item steps, coefficient derivation and result handoff.
module cds_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  cds_pkg::stat_t stat,
    output cds_pkg::cmd_t  cmd
);
    import cds_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_OUT   = 3'd2;
    localparam logic [2:0] S_DISS  = 3'd3;
    localparam logic [2:0] S_DWAIT = 3'd4;
    localparam logic [2:0] S_DWB   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [3:0] sidx_reg, sidx_next;
    logic [2:0] dop_reg, dop_next;
    logic       mval_reg, mval_next;

    always_comb begin
        state_next   = state_reg;
        sidx_next    = sidx_reg;
        dop_next     = dop_reg;
        cmd          = '0;
        cmd.step_op  = sidx_reg;
        cmd.d_op     = dop_reg;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    sidx_next  = ST_CLAMP;
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                cmd.step_en = 1'b1;
                if (sidx_reg == ST_A5) state_next = S_OUT;
                else                   sidx_next  = sidx_reg + 1'b1;
            end
            S_OUT: begin
                if (!mval_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DISS: begin
                if (dop_reg == D_X2 && stat.x_big) begin
                    dop_next = D_LIM;
                end else begin
                    cmd.d_issue = 1'b1;
                    state_next  = S_DWAIT;
                end
            end
            S_DWAIT: if (stat.ser_done) state_next = S_DWB;
            S_DWB: begin
                cmd.d_wb = 1'b1;
                if (dop_reg == D_LIM) begin
                    state_next = S_IDLE;
                end else begin
                    dop_next   = dop_reg + 1'b1;
                    state_next = S_DISS;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg_wr_en) begin
            state_next = S_DISS;
            dop_next   = D_OMEGA;
        end
        if (cmd.out_load)  mval_next = 1'b1;
        else if (m_tready) mval_next = 1'b0;
        else               mval_next = mval_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_DISS;
            sidx_reg  <= ST_CLAMP;
            dop_reg   <= D_OMEGA;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sidx_reg  <= sidx_next;
            dop_reg   <= dop_next;
            mval_reg  <= mval_next;
        end
    end

    assign m_tvalid = mval_reg;

`ifndef NO_ASSERTIONS
    a_step_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_STEP && sidx_reg == ST_A5 |=> state_reg == S_OUT || state_reg == S_DISS)
        else $error("step sequence did not end in result handoff");
    a_no_issue_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DWAIT && !stat.ser_done && !cfg_wr_en |=> state_reg == S_DWAIT)
        else $error("derivation left wait without serial done");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !mval_reg || m_tready)
        else $error("result register overwritten while held");
`endif

endmodule

// ===== rtl/critically_damped_smoother.sv =====
// Top level of the critically damped smooth-damp follower (signed fixed point).
//
//   channel  | ports                      | content (low bits first)
//   ---------+----------------------------+-----------------------------------
//   input    | s_tvalid s_tready s_tdata  | current_value[31:0], goal_value[63:32]
//   result   | m_tvalid m_tready m_tdata  | smoothed_value[31:0], new_velocity[63:32]
//   config   | cfg_wr_en cfg_index cfg_wdata | 0 smooth_time, 1 max_speed, 2 time_step
//
// Each request runs a clamp, five multiply/saturate pairs on one shared 32x32
// multiplier, then the handoff to the result register; the next request is
// taken only after that handoff.
// Velocity feeds back into the next request, so one request is in work at a time.
// After reset and after every register write, omega, decay and change limit are
// rederived on a 64-bit bit-serial multiply/divide unit in eight operations (the
// polynomial is skipped when the decay underflows to zero); s_tready stays low
// until that is done.
// The result register frees the datapath: a new request is taken while the
// previous result still waits on m_tready; only the next handoff stalls.
module critically_damped_smoother #(
    parameter int FRAC_BITS = cds_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // current_value, goal_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // smoothed_value, new_velocity
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import cds_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cds_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cds_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .out_data  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input taken during coefficient derivation");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");
`endif

endmodule

// ===== tb/cds_checker.sv =====
// Checker: predicts smoother results from observed traffic and compares them.
module cds_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import cds_pkg::*;

    localparam int F = FRAC_BITS_DEF;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint unsigned ONE_Q = 64'd1 << F;
    localparam longint unsigned MIN_ST = (ONE_Q + 64'd9999) / 64'd10000;

    // smoothed value in the low half, as on m_tdata
    typedef struct packed {
        logic [31:0] velocity;
        logic [31:0] smoothed;
    } step_out_t;

    step_out_t due_q[$];

    longint unsigned st_reg, speed_reg, dt_reg;
    longint vel, omega, decay, limit;

    function automatic longint sat32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // truncating fixed-point product, saturated
    function automatic longint fmul(longint a, longint b);
        logic neg;
        longint unsigned ua, ub, p;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        p = (ua * ub) >> F;
        return sat32(neg ? -longint'(p) : longint'(p));
    endfunction

    task automatic rederive();
        longint unsigned st, om, x, x2, x3, den, lim;
        st = (st_reg < MIN_ST) ? MIN_ST : st_reg;
        om = (64'd2 << (2 * F)) / st;
        if (om > S32_MAX) om = S32_MAX;
        omega = om;
        x = (om * dt_reg) >> F;
        if (x > (ONE_Q << 10)) begin
            decay = 0;
        end else begin
            x2 = (x * x) >> F;
            x3 = (x2 * x) >> F;
            den = ONE_Q + x + (x2 * 48) / 100 + (x3 * 235) / 1000;
            decay = (64'd1 << (2 * F)) / den;
        end
        lim = (speed_reg * st) >> F;
        if (lim > S32_MAX) lim = S32_MAX;
        limit = lim;
    endtask

    function automatic step_out_t smooth_step(logic [63:0] d);
        longint cur, goal, chg, tgt, tmp, res, nv;
        step_out_t r;
        cur = longint'($signed(d[31:0]));
        goal = longint'($signed(d[63:32]));
        chg = cur - goal;
        if (chg > limit) chg = limit;
        if (chg < -limit) chg = -limit;
        tgt = cur - chg;
        tmp = fmul(sat32(vel + fmul(omega, chg)), longint'(dt_reg));
        nv = fmul(sat32(vel - fmul(omega, tmp)), decay);
        res = sat32(tgt + fmul(sat32(chg + tmp), decay));
        // overshoot: snap to goal and stop
        if ((goal > cur) == (res > goal)) begin
            res = goal;
            nv = 0;
        end
        vel = nv;
        r.smoothed = res[31:0];
        r.velocity = nv[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s at %0t: got %h want %h", what, $time, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        step_out_t e, g;
        if (!aresetn) begin
            st_reg = SMOOTH_TIME_RST;
            speed_reg = MAX_SPEED_RST;
            dt_reg = TIME_STEP_RST;
            vel = 0;
            rederive();
            due_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SMOOTH_TIME: begin st_reg = cfg_wdata; rederive(); end
                    CFG_MAX_SPEED: begin speed_reg = cfg_wdata[30:0]; rederive(); end
                    CFG_TIME_STEP: begin dt_reg = cfg_wdata[16:0]; rederive(); end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) due_q.insert(due_q.size(), smooth_step(s_tdata));
            if (m_tvalid && m_tready) begin
                g = m_tdata;
                if (due_q.size() == 0) begin
                    report("unexpected result", g.smoothed, 32'd0);
                end else begin
                    e = due_q.pop_front();
                    if (g.smoothed != e.smoothed) report("smoothed", g.smoothed, e.smoothed);
                    if (g.velocity != e.velocity) report("velocity", g.velocity, e.velocity);
                end
            end
        end
        pending = due_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: stimulus, idling, config phases and verdict for the smoother.
module tb_top;
    import cds_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [63:0] s_tdata;   // current_value[31:0], goal_value[63:32]
    logic        m_tvalid, m_tready;
    logic [63:0] m_tdata;   // smoothed_value[31:0], new_velocity[63:32]
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    int          fail_count, pending;

    // pacing controls shared between sender and receiver
    bit quiet;          // no idling on either side
    bit hold_req;       // ask receiver for one long hold-off
    bit sending_done;
    int idle_count;

    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;  // covers a derive pass plus the long hold

    critically_damped_smoother uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    cds_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // random value with random magnitude, so small and huge both show up
    function automatic logic [31:0] rand_val();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    // one request; valid stays high across back-to-back requests
    task automatic send(logic [31:0] cur, logic [31:0] goal);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {goal, cur};
        do @(posedge aclk); while (!s_tready);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] st, logic [31:0] spd, logic [31:0] dt);
        write_reg(CFG_SMOOTH_TIME, st);
        write_reg(CFG_MAX_SPEED, spd);
        write_reg(CFG_TIME_STEP, dt);
    endtask

    // mostly follow-the-goal runs, some pure noise
    task automatic random_phase(int n);
        int k;
        longint cur, goal, div;
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 3) == 0) begin
                send($urandom, $urandom);
                k++;
            end else begin
                cur = longint'($signed(rand_val()));
                goal = longint'($signed(rand_val()));
                div = $urandom_range(1, 8);
                repeat ($urandom_range(5, 25)) begin
                    send(cur[31:0], goal[31:0]);
                    cur = cur + (goal - cur) / div;
                    if ($urandom_range(0, 15) == 0) goal = longint'($signed(rand_val()));
                    k++;
                end
            end
            if ($urandom_range(0, 40) == 0) quiet = ~quiet;
        end
    endtask

    // receiver: random readiness, one long hold on request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = draw_gap();
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog: cycles with no accepted request, result or write
    initial begin
        idle_count = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_count = 0;
            else if (!sending_done || pending != 0)
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SMOOTH_TIME;
        cfg_wdata = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        sending_done = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, goal equal to current, tiny offsets
        send(32'h0000_0000, 32'h0000_0000);
        send(32'h7FFF_FFFF, 32'h8000_0000);
        send(32'h8000_0000, 32'h7FFF_FFFF);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(32'h8000_0000, 32'h8000_0000);
        send(32'h0001_0000, 32'h0001_0000);
        send(32'h0000_0001, 32'h0000_0000);
        send(32'h0000_0000, 32'h0000_0001);
        send(32'hFFFF_FFFF, 32'h0000_0000);
        send(32'h0010_0000, 32'hFFF0_0000);
        send(32'hFFF0_0000, 32'h0010_0000);
        send(32'hFFF8_0000, 32'h0010_0000);

        // smallest smooth time (raised to minimum), no speed, zero step
        set_all(32'h0, 32'h0, 32'h0);
        send(32'h7FFF_FFFF, 32'h8000_0000);
        send(32'h0000_1000, 32'h0000_0000);
        send(32'h0000_1000, 32'h0000_1000);
        write_reg(CFG_TIME_STEP, 32'd1);
        send(32'h8000_0000, 32'h7FFF_FFFF);
        send(32'h0000_0100, 32'h0000_0000);
        // largest everything: largest step the register holds, huge smooth time
        set_all(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1_FFFF);
        send(32'h7FFF_FFFF, 32'h8000_0000);
        send(32'h8000_0000, 32'h7FFF_FFFF);
        send(32'h0000_0000, 32'h0001_0000);
        random_phase(150);

        // back to defaults-like settings with a long output hold
        set_all(32'h0001_0000, 32'h7FFF_FFFF, 32'd1092);
        quiet = 1'b1;
        hold_req = 1'b1;
        random_phase(60);
        quiet = 1'b0;
        random_phase(240);

        // short smooth time, big step: decay hits zero
        set_all(32'd7, 32'h0000_8000, 32'd65536);
        random_phase(200);

        // moderate speed limit clamps the change
        set_all(32'h0000_4000, 32'h0002_0000, 32'd4096);
        random_phase(250);

        // slow approach with fine step
        set_all(32'h0010_0000, 32'h0100_0000, 32'd1);
        random_phase(200);

        repeat (3) begin
            set_all($urandom, $urandom, $urandom_range(0, 131071));
            random_phase(180);
        end

        s_tvalid <= 1'b0;
        sending_done = 1'b1;
        wait (pending == 0);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cds_pkg.sv
rtl/cds_serial.sv
rtl/cds_dp.sv
rtl/cds_ctrl.sv
rtl/critically_damped_smoother.sv
tb/cds_checker.sv
tb/tb_top.sv
